// ===== hw/rtl/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Random scan permutation package
// Widths, capacity and result status codes shared by the permutation block.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int RAND_W      = 16;
    localparam int PROD_W      = RAND_W + CNT_W;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [1:0]        t_status;

    localparam t_status ST_DRAWN     = 2'd0;
    localparam t_status ST_EXHAUSTED = 2'd1;
    localparam t_status ST_RESTARTED = 2'd2;
    localparam t_status ST_REJECTED  = 2'd3;

    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_DRAW    = 1'b1;

endpackage

// ===== hw/rtl/rsp_ram.sv =====
// ----------------------------------------------------------------------------
// Order table memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rsp_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hw/rtl/random_scan_permutation_top.sv =====
// ----------------------------------------------------------------------------
// Random scan permutation
// Draws the indices 0..N-1 in random order, each once per scan.
// ----------------------------------------------------------------------------
// The input stream carries commands: tuser bit 0 is the command (restart or
// draw) and tdata holds the random fraction used by a draw. Every accepted
// command yields exactly one result on the output stream: tdata holds the
// drawn index and tuser the status (drawn, exhausted, restarted, rejected).
// The scan length is written on the configuration channel; the user must
// do so only while idle, and the block itself does not enforce it.
// A restart writes the identity into the order table through the single
// memory write port, one entry per cycle, and then loads the result. A draw
// runs through a multiply for the slot, the registered two-port read, the
// write back of the last live entry into the picked slot, and the load of
// the output register. A rejected restart or an exhausted draw goes straight
// to the load of the output register. One command is in work at a time;
// the next transfer is taken once the block is back in idle after the
// result is loaded. A new command is accepted while the previous result
// still waits on the output. If the receiver stalls, the block holds its
// finished result and waits. Reset clears the remaining count, the scan
// length and the output valid.
// ----------------------------------------------------------------------------
module random_scan_permutation_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: scan length
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data,    // [12:0] scan_total
    // Command stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,     // [15:0] random_fraction
    input  logic [0:0]  i_s_tuser,     // [0] command
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,     // [11:0] drawn_index, [15:12] zero
    output logic [1:0]  o_m_tuser      // [1:0] status
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FILL  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                   r_state, n_state;
    rsp_pkg::t_cnt                r_total;
    rsp_pkg::t_cnt                r_remaining, n_remaining;
    rsp_pkg::t_addr               r_cnt, n_cnt;
    logic [rsp_pkg::RAND_W-1:0]   r_frac, n_frac;
    logic [rsp_pkg::PROD_W-1:0]   r_prod, n_prod;
    rsp_pkg::t_addr               r_slot, n_slot;
    rsp_pkg::t_addr               r_res_index, n_res_index;
    rsp_pkg::t_status             r_res_status, n_res_status;
    logic                         r_out_valid, n_out_valid;
    rsp_pkg::t_addr               r_out_index, n_out_index;
    rsp_pkg::t_status             r_out_status, n_out_status;

    logic                         mem_we;
    rsp_pkg::t_addr               mem_waddr;
    rsp_pkg::t_addr               mem_wdata;
    rsp_pkg::t_addr               rd_slot;
    rsp_pkg::t_addr               rd_last;
    rsp_pkg::t_addr               last_addr;
    logic                         in_xfer;
    logic                         total_ok;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign in_xfer     = i_s_tvalid && o_s_tready;
    assign total_ok    = (r_total != '0) &&
                         (r_total <= rsp_pkg::t_cnt'(rsp_pkg::MAX_ENTRIES));
    assign last_addr   = rsp_pkg::t_addr'(r_remaining - 1'b1);

    rsp_ram #(
        .DEPTH (rsp_pkg::MAX_ENTRIES),
        .WIDTH (rsp_pkg::ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (n_slot),
        .i_raddr_b (last_addr),
        .o_rdata_a (rd_slot),
        .o_rdata_b (rd_last)
    );

    always_comb begin
        n_state      = r_state;
        n_remaining  = r_remaining;
        n_cnt        = r_cnt;
        n_frac       = r_frac;
        n_prod       = r_prod;
        n_slot       = r_slot;
        n_res_index  = r_res_index;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_index  = r_out_index;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = r_cnt;
        mem_wdata    = r_cnt;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_frac      = i_s_tdata;
                    n_res_index = '0;
                    n_cnt       = '0;
                    if (i_s_tuser[0] == rsp_pkg::CMD_RESTART) begin
                        if (total_ok) begin
                            n_remaining  = r_total;
                            n_res_status = rsp_pkg::ST_RESTARTED;
                            n_state      = S_FILL;
                        end else begin
                            n_remaining  = '0;
                            n_res_status = rsp_pkg::ST_REJECTED;
                            n_state      = S_DONE;
                        end
                    end else if (r_remaining == '0) begin
                        n_res_status = rsp_pkg::ST_EXHAUSTED;
                        n_state      = S_DONE;
                    end else begin
                        n_res_status = rsp_pkg::ST_DRAWN;
                        n_state      = S_MUL;
                    end
                end
            end
            S_FILL: begin
                // Identity fill, one entry per cycle through the write port.
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if ({1'b0, r_cnt} == r_total - 1'b1) begin
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                n_prod  = rsp_pkg::PROD_W'(r_frac) * rsp_pkg::PROD_W'(r_remaining);
                n_state = S_READ;
            end
            S_READ: begin
                // The product is below remaining times 2^RAND_W, so the slot fits.
                n_slot  = r_prod[rsp_pkg::RAND_W +: rsp_pkg::ADDR_W];
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // Read data for both the picked slot and the last live entry
                // is valid now; move the last entry into the picked slot.
                mem_we      = 1'b1;
                mem_waddr   = r_slot;
                mem_wdata   = rd_last;
                n_res_index = rd_slot;
                n_remaining = r_remaining - 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = r_res_index;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The read addresses must settle in the state before the write-back state.
    // r_slot is loaded in S_READ, so the registered read lands in S_WRITE only
    // if the address is presented in S_READ; compute it early from the product.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= '0;
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_frac       <= n_frac;
        r_prod       <= n_prod;
        r_slot       <= n_slot;
        r_res_index  <= n_res_index;
        r_res_status <= n_res_status;
        r_out_index  <= n_out_index;
        r_out_status <= n_out_status;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16 - rsp_pkg::ADDR_W){1'b0}}, r_out_index};
    assign o_m_tuser  = r_out_status;

    a_remaining_cap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_remaining <= rsp_pkg::t_cnt'(rsp_pkg::MAX_ENTRIES))
        else $error("remaining count above capacity");

    a_fill_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ({1'b0, r_cnt} < r_remaining))
        else $error("fill address beyond scan length");

    a_draw_decrements : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |=> (r_remaining == $past(r_remaining) - 1'b1))
        else $error("draw did not consume one entry");

    a_index_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != rsp_pkg::ST_DRAWN)) |-> (o_m_tdata == '0))
        else $error("index nonzero on a non-draw result");

    a_slot_live : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> ({1'b0, r_slot} < r_remaining))
        else $error("picked slot outside live entries");

endmodule
